[rtl/two_priority_ring_queue_macros.svh]
// ----------------------------------------------------------------------------
// Two priority ring queue: assertion macros
// Concurrent assertion helpers used by the ring pointer RTL. They are empty in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef TWO_PRIORITY_RING_QUEUE_MACROS_SVH
`define TWO_PRIORITY_RING_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
`define TPRQ_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("tprq assertion failed");
`define TPRQ_ASSERT_NEVER(label, clk, rst_n, expr) \
	`TPRQ_ASSERT(label, clk, rst_n, !(expr))
`else
`define TPRQ_ASSERT(label, clk, rst_n, prop)
`define TPRQ_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

[rtl/tprq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two priority ring queue package
// Sizes, operation codes and the word types shared by the queue modules.
// ----------------------------------------------------------------------------
package tprq_pkg;

	localparam int DEPTH  = 16;
	localparam int WORD_W = 32;
	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	localparam logic [1:0] SEL_HIGH   = 2'd0;
	localparam logic [1:0] SEL_LOW    = 2'd1;
	localparam logic [1:0] SEL_EITHER = 2'd2;

	typedef struct packed {
		logic                     op;
		logic [1:0]               queue_select;
		logic signed [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                     ok;
		logic signed [WORD_W-1:0] read_value;
		logic [4:0]               count_high;
		logic [4:0]               count_low;
		logic [5:0]               count_total;
	} rsp_t;

	typedef struct packed {
		logic push;
		logic pop;
	} ring_cmd_t;

	typedef struct packed {
		logic [PTR_W-1:0]  wr_ptr;
		logic [PTR_W-1:0]  rd_ptr;
		logic [FILL_W-1:0] fill;
		logic [FILL_W-1:0] fill_next;
		logic              full;
		logic              empty;
	} ring_stat_t;

endpackage

[rtl/two_priority_ring_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two priority ring queue
// A high and a low priority circular FIFO of signed words held in RAM.
// ----------------------------------------------------------------------------
// Request words arrive on req (req_valid, req_stall) and each one yields
// exactly one response word on rsp (rsp_valid, rsp_stall). A request either
// inserts its value or extracts a word, from the high queue, the low queue
// or either, in which case the high queue is served first.
// The decision is taken from the fill counts as the request is accepted.
// The RAM read for an extract is registered alongside the request in the
// read stage, and the response register follows the read stage.
// One request is accepted every cycle while req_stall is low; each queue
// has a single registered RAM read port.
// When the response register is full and rsp_stall is high, the request
// held in the read stage waits and req_stall is raised until it can move.
// Reset empties both queues and clears the response valid flag. The RAM
// contents are not cleared; only entries that were written are ever read.
// ----------------------------------------------------------------------------
module two_priority_ring_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  tprq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output tprq_pkg::rsp_t rsp
);
	import tprq_pkg::*;

	ring_cmd_t  hi_cmd;
	ring_cmd_t  lo_cmd;
	ring_stat_t hi_stat;
	ring_stat_t lo_stat;

	logic              accept;
	logic              out_free;
	logic              ok;
	logic [WORD_W-1:0] hi_rdata;
	logic [WORD_W-1:0] lo_rdata;

	logic              valid_s1;
	logic              ok_s1;
	logic              pop_hi_s1;
	logic              pop_lo_s1;
	logic [4:0]        count_hi_s1;
	logic [4:0]        count_lo_s1;
	logic [5:0]        count_tot_s1;

	logic              rsp_valid_q;
	rsp_t              rsp_q;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !out_free;
	assign accept    = req_valid && !req_stall;

	always_comb begin
		hi_cmd = '0;
		lo_cmd = '0;
		if (req.op == OP_INSERT) begin
			case (req.queue_select)
				SEL_HIGH: hi_cmd.push = !hi_stat.full;
				SEL_LOW:  lo_cmd.push = !lo_stat.full;
				SEL_EITHER: begin
					hi_cmd.push = !hi_stat.full;
					lo_cmd.push = hi_stat.full && !lo_stat.full;
				end
				default: ;
			endcase
		end else begin
			case (req.queue_select)
				SEL_HIGH: hi_cmd.pop = !hi_stat.empty;
				SEL_LOW:  lo_cmd.pop = !lo_stat.empty;
				SEL_EITHER: begin
					hi_cmd.pop = !hi_stat.empty;
					lo_cmd.pop = hi_stat.empty && !lo_stat.empty;
				end
				default: ;
			endcase
		end
		if (!accept) begin
			hi_cmd = '0;
			lo_cmd = '0;
		end
	end

	assign ok = hi_cmd.push || hi_cmd.pop || lo_cmd.push || lo_cmd.pop;

	tprq_ring u_hi_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (hi_cmd),
		.stat   (hi_stat)
	);

	tprq_ring u_lo_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (lo_cmd),
		.stat   (lo_stat)
	);

	tprq_ram #(
		.DEPTH_P (DEPTH),
		.WIDTH_P (WORD_W)
	) u_hi_ram (
		.clk   (clk),
		.we    (hi_cmd.push),
		.waddr (hi_stat.wr_ptr),
		.wdata ($unsigned(req.value)),
		.re    (hi_cmd.pop),
		.raddr (hi_stat.rd_ptr),
		.rdata (hi_rdata)
	);

	tprq_ram #(
		.DEPTH_P (DEPTH),
		.WIDTH_P (WORD_W)
	) u_lo_ram (
		.clk   (clk),
		.we    (lo_cmd.push),
		.waddr (lo_stat.wr_ptr),
		.wdata ($unsigned(req.value)),
		.re    (lo_cmd.pop),
		.raddr (lo_stat.rd_ptr),
		.rdata (lo_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1        <= ok;
			pop_hi_s1    <= hi_cmd.pop;
			pop_lo_s1    <= lo_cmd.pop;
			count_hi_s1  <= 5'(hi_stat.fill_next);
			count_lo_s1  <= 5'(lo_stat.fill_next);
			count_tot_s1 <= 6'({1'b0, hi_stat.fill_next} + {1'b0, lo_stat.fill_next});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			rsp_q.ok          <= ok_s1;
			rsp_q.read_value  <= pop_hi_s1 ? $signed(hi_rdata) :
			                     pop_lo_s1 ? $signed(lo_rdata) : '0;
			rsp_q.count_high  <= count_hi_s1;
			rsp_q.count_low   <= count_lo_s1;
			rsp_q.count_total <= count_tot_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/tprq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two priority ring queue: storage RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tprq_ram #(
	parameter int DEPTH_P = 16,
	parameter int WIDTH_P = 32,
	parameter int ADDR_W  = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
	input  logic               clk,
	input  logic               we,
	input  logic [ADDR_W-1:0]  waddr,
	input  logic [WIDTH_P-1:0] wdata,
	input  logic               re,
	input  logic [ADDR_W-1:0]  raddr,
	output logic [WIDTH_P-1:0] rdata
);

	logic [WIDTH_P-1:0] mem [DEPTH_P];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/tprq_ring.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two priority ring queue: ring pointers
// Write pointer, read pointer and fill count of one circular queue.
// ----------------------------------------------------------------------------
`include "two_priority_ring_queue_macros.svh"

module tprq_ring (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tprq_pkg::ring_cmd_t  cmd,
	output tprq_pkg::ring_stat_t stat
);
	import tprq_pkg::*;

	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_next;

	always_comb begin
		fill_next = fill_q;
		if (cmd.push) begin
			fill_next = fill_q + FILL_W'(1);
		end else if (cmd.pop) begin
			fill_next = fill_q - FILL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (cmd.push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (cmd.pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			fill_q <= fill_next;
		end
	end

	assign stat.wr_ptr    = wr_ptr_q;
	assign stat.rd_ptr    = rd_ptr_q;
	assign stat.fill      = fill_q;
	assign stat.fill_next = fill_next;
	assign stat.full      = (fill_q == FILL_W'(DEPTH));
	assign stat.empty     = (fill_q == '0);

	`TPRQ_ASSERT_NEVER(a_fill_range, clk, arst_n, fill_q > FILL_W'(DEPTH))
	`TPRQ_ASSERT_NEVER(a_push_full, clk, arst_n, cmd.push && (fill_q == FILL_W'(DEPTH)))
	`TPRQ_ASSERT_NEVER(a_pop_empty, clk, arst_n, cmd.pop && (fill_q == '0))
	`TPRQ_ASSERT(a_fill_step, clk, arst_n, cmd.push |=> fill_q == $past(fill_q) + FILL_W'(1))

endmodule
